>>> hw/rtl/bftl_pkg.sv
// ----------------------------------------------------------------------------
// bftl_pkg
// Shared types, codes and the byte-to-token map of the run-length lexer.
// ----------------------------------------------------------------------------
package bftl_pkg;

  localparam int NEST_DEPTH_DEF = 256;
  localparam int INDEX_BITS_DEF = 16;

  localparam int OUT_W   = 16;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] RUN_MAX = '1;

  // token types; NO_CMD marks a byte that is not a command
  localparam logic [3:0] CMD_INC   = 4'd0;
  localparam logic [3:0] CMD_DEC   = 4'd1;
  localparam logic [3:0] CMD_RIGHT = 4'd2;
  localparam logic [3:0] CMD_LEFT  = 4'd3;
  localparam logic [3:0] CMD_OUT   = 4'd4;
  localparam logic [3:0] CMD_IN    = 4'd5;
  localparam logic [3:0] CMD_OPEN  = 4'd6;
  localparam logic [3:0] CMD_CLOSE = 4'd7;
  localparam logic [3:0] NO_CMD    = 4'd8;

  localparam logic [2:0] TOK_OPEN  = 3'd6;
  localparam logic [2:0] TOK_CLOSE = 3'd7;

  localparam logic KIND_TOKEN  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNMATCHED = 3'd1;
  localparam logic [2:0] ST_UNCLOSED  = 3'd2;
  localparam logic [2:0] ST_NEST_OVF  = 3'd3;
  localparam logic [2:0] ST_TOKEN_OVF = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef struct packed {
    logic               kind;
    logic [2:0]         token_type;
    logic [COUNT_W-1:0] repeat_count;
    logic [OUT_W-1:0]   token_index;
    logic [OUT_W-1:0]   partner_index;
    logic [2:0]         status_code;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     r;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } grp_push_t;

  function automatic logic [3:0] map_byte(input logic [7:0] b);
    logic [3:0] t;
    case (b)
      CH_PLUS:  t = CMD_INC;
      CH_MINUS: t = CMD_DEC;
      CH_GT:    t = CMD_RIGHT;
      CH_LT:    t = CMD_LEFT;
      CH_DOT:   t = CMD_OUT;
      CH_COMMA: t = CMD_IN;
      CH_LBRK:  t = CMD_OPEN;
      CH_RBRK:  t = CMD_CLOSE;
      default:  t = NO_CMD;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/bftl_core.sv
// ----------------------------------------------------------------------------
// bftl_core
// Run state, token counter and bracket stack; builds the result group of
// each accepted byte in one pass.
// ----------------------------------------------------------------------------
module bftl_core #(
  parameter int NEST_DEPTH = bftl_pkg::NEST_DEPTH_DEF,
  parameter int INDEX_BITS = bftl_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          source_byte,
  input  logic                end_of_source,
  output bftl_pkg::grp_push_t push
);

  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int AW = $clog2(NEST_DEPTH);
  localparam int IB = INDEX_BITS;

  typedef struct packed {
    logic                           failed;
    logic [2:0]                     fail_code;
    logic [bftl_pkg::COUNT_W-1:0]   run_count;
    logic [IB:0]                    next_index;
    logic [1:0]                     n;
    logic                           ok;
    bftl_pkg::res_t [2:0]           res;
  } lex_st_t;

  logic [2:0]                   run_type_r;
  logic [bftl_pkg::COUNT_W-1:0] run_count_r;
  logic [IB:0]                  next_index_r;
  logic [LW-1:0]                level_r, level_nxt;
  logic                         failed_r;
  logic [2:0]                   fail_code_r;
  logic [IB-1:0]                top_r, top_nxt;
  logic [IB-1:0]                rd_r;
  logic [IB-1:0]                mem [NEST_DEPTH];

  lex_st_t                      st;
  logic [2:0]                   rt;
  logic [3:0]                   cmd;
  logic                         wr_en;
  logic [IB-1:0]                wr_data;
  logic [AW-1:0]                rd_addr;

  function automatic logic [bftl_pkg::OUT_W-1:0] to_out(input logic [IB-1:0] v);
    logic [IB+bftl_pkg::OUT_W-1:0] w;
    w = (IB + bftl_pkg::OUT_W)'(v);
    return w[bftl_pkg::OUT_W-1:0];
  endfunction

  function automatic lex_st_t fail(input lex_st_t s, input logic [2:0] code);
    lex_st_t o;
    o = s;
    if (!o.failed) begin
      o.failed    = 1'b1;
      o.fail_code = code;
    end
    o.run_count = '0;
    return o;
  endfunction

  function automatic lex_st_t tok(input lex_st_t s, input logic [2:0] ty,
                                  input logic [bftl_pkg::COUNT_W-1:0] cnt,
                                  input logic [IB-1:0] partner);
    lex_st_t o;
    o = s;
    o.ok = 1'b0;
    if (!o.failed) begin
      if (o.next_index[IB]) begin
        o = fail(o, bftl_pkg::ST_TOKEN_OVF);
      end else begin
        o.res[o.n].kind          = bftl_pkg::KIND_TOKEN;
        o.res[o.n].token_type    = ty;
        o.res[o.n].repeat_count  = cnt;
        o.res[o.n].token_index   = to_out(o.next_index[IB-1:0]);
        o.res[o.n].partner_index = to_out(partner);
        o.res[o.n].status_code   = bftl_pkg::ST_OK;
        o.n          = o.n + 2'd1;
        o.next_index = o.next_index + (IB + 1)'(1);
        o.ok         = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic lex_st_t flush(input lex_st_t s, input logic [2:0] ty);
    lex_st_t o;
    o = s;
    if (o.run_count != '0 && !o.failed) begin
      o = tok(o, ty, o.run_count, '0);
    end
    o.run_count = '0;
    return o;
  endfunction

  always_comb begin
    st            = '0;
    st.failed     = failed_r;
    st.fail_code  = fail_code_r;
    st.run_count  = run_count_r;
    st.next_index = next_index_r;
    rt            = run_type_r;
    level_nxt     = level_r;
    top_nxt       = top_r;
    wr_en         = 1'b0;
    wr_data       = next_index_r[IB-1:0];
    cmd           = bftl_pkg::map_byte(source_byte);
    if (acc) begin
      if (!st.failed) begin
        if (cmd <= bftl_pkg::CMD_IN) begin
          if (st.run_count != '0 && rt == cmd[2:0] && st.run_count != bftl_pkg::RUN_MAX) begin
            st.run_count = st.run_count + bftl_pkg::COUNT_W'(1);
          end else begin
            st = flush(st, rt);
            if (!st.failed) begin
              rt           = cmd[2:0];
              st.run_count = bftl_pkg::COUNT_W'(1);
            end
          end
        end else if (cmd == bftl_pkg::CMD_OPEN) begin
          st = flush(st, rt);
          if (!st.failed) begin
            if (level_r == LW'(NEST_DEPTH)) begin
              st = fail(st, bftl_pkg::ST_NEST_OVF);
            end else begin
              wr_data = st.next_index[IB-1:0];
              st = tok(st, bftl_pkg::TOK_OPEN, bftl_pkg::COUNT_W'(1), '0);
              if (st.ok) begin
                wr_en     = 1'b1;
                top_nxt   = wr_data;
                level_nxt = level_r + LW'(1);
              end
            end
          end
        end else if (cmd == bftl_pkg::CMD_CLOSE) begin
          st = flush(st, rt);
          if (!st.failed) begin
            if (level_r == '0) begin
              st = fail(st, bftl_pkg::ST_UNMATCHED);
            end else begin
              st = tok(st, bftl_pkg::TOK_CLOSE, bftl_pkg::COUNT_W'(1), top_r);
              if (st.ok) begin
                top_nxt   = rd_r;
                level_nxt = level_r - LW'(1);
              end
            end
          end
        end
      end
      if (end_of_source) begin
        st = flush(st, rt);
        if (!st.failed && level_nxt != '0) begin
          st = fail(st, bftl_pkg::ST_UNCLOSED);
        end
        st.res[st.n]             = '0;
        st.res[st.n].kind        = bftl_pkg::KIND_STATUS;
        st.res[st.n].status_code = st.failed ? st.fail_code : bftl_pkg::ST_OK;
        st.n          = st.n + 2'd1;
        rt            = '0;
        st.run_count  = '0;
        st.next_index = '0;
        st.failed     = 1'b0;
        st.fail_code  = bftl_pkg::ST_OK;
        level_nxt     = '0;
      end
    end
    rd_addr        = AW'(level_nxt - LW'(2));
    push.valid     = acc && (st.n != 2'd0);
    push.grp.cnt   = st.n;
    push.grp.r     = st.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_type_r   <= '0;
      run_count_r  <= '0;
      next_index_r <= '0;
      level_r      <= '0;
      failed_r     <= 1'b0;
      fail_code_r  <= bftl_pkg::ST_OK;
    end else begin
      run_type_r   <= rt;
      run_count_r  <= st.run_count;
      next_index_r <= st.next_index;
      level_r      <= level_nxt;
      failed_r     <= st.failed;
      fail_code_r  <= st.fail_code;
    end
  end

  // stack: mem holds every entry, top_r mirrors the top, rd_r the one below
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (wr_en) begin
      mem[level_r[AW-1:0]] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/bftl_outq.sv
// ----------------------------------------------------------------------------
// bftl_outq
// Two-group result buffer; sends the results of each group one beat at a time.
// ----------------------------------------------------------------------------
module bftl_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  bftl_pkg::grp_push_t push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output bftl_pkg::res_t      res,
  output logic                last
);

  bftl_pkg::group_t grp_r [2];
  logic             wr_r, rd_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       slot_r;
  logic             beat, pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign res       = grp_r[rd_r].r[slot_r];
  assign last      = (slot_r == grp_r[rd_r].cnt - 2'd1);
  assign beat      = out_valid && !out_stall;
  assign pop       = beat && last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r   <= !rd_r;
        slot_r <= '0;
      end else if (beat) begin
        slot_r <= slot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      grp_r[wr_r] <= push.grp;
    end
  end

endmodule

>>> hw/rtl/brainfuck_token_lexer.sv
// ----------------------------------------------------------------------------
// brainfuck_token_lexer
// Run-length lexer for program bytes with bracket matching and status report.
// ----------------------------------------------------------------------------
//  channel | ports                                      | role
//  in      | in_valid, in_stall, in_source_byte,        | one program byte
//          | in_end_of_source                           |
//  out     | out_valid, out_stall, out_result_kind ...  | token or status beat
//
//  One byte is taken per cycle while in_stall is low; its state update is done in the same cycle.
//  A byte yields zero to three results, sent from a two-group buffer one per
//  cycle while out_stall is low; in_stall rises only while both groups are occupied.
//  Sustained rate while out_stall is low: one byte per cycle, or one result per
//  cycle when the output beats outnumber the bytes.
//  Synchronous reset clears run state, counter, stack level and buffer.
// ----------------------------------------------------------------------------
module brainfuck_token_lexer #(
  parameter int NEST_DEPTH = bftl_pkg::NEST_DEPTH_DEF,
  parameter int INDEX_BITS = bftl_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [2:0]  out_token_type,
  output logic [15:0] out_repeat_count,
  output logic [15:0] out_token_index,
  output logic [15:0] out_partner_index,
  output logic [2:0]  out_status_code,
  output logic        out_last_of_run
);

  bftl_pkg::grp_push_t push;
  bftl_pkg::res_t      res;
  logic                full;
  logic                acc;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  bftl_core #(
    .NEST_DEPTH(NEST_DEPTH),
    .INDEX_BITS(INDEX_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .source_byte   (in_source_byte),
    .end_of_source (in_end_of_source),
    .push          (push)
  );

  bftl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .last      (out_last_of_run)
  );

  assign out_result_kind   = res.kind;
  assign out_token_type    = res.token_type;
  assign out_repeat_count  = res.repeat_count;
  assign out_token_index   = res.token_index;
  assign out_partner_index = res.partner_index;
  assign out_status_code   = res.status_code;

endmodule

>>> hw/rtl/bftl_checker.sv
// ----------------------------------------------------------------------------
// bftl_checker
// Port-level checks on the result channel of the lexer.
// ----------------------------------------------------------------------------
module bftl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [2:0]  out_token_type,
  input logic [15:0] out_repeat_count,
  input logic [15:0] out_token_index,
  input logic [15:0] out_partner_index,
  input logic [2:0]  out_status_code,
  input logic        out_last_of_run
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_index) &&
      $stable(out_result_kind) && $stable(out_last_of_run))
    else $error("out beat changed under stall");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == bftl_pkg::KIND_STATUS |-> out_last_of_run)
    else $error("status beat not last of its byte");

  a_token_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == bftl_pkg::KIND_TOKEN |->
      out_status_code == bftl_pkg::ST_OK && out_repeat_count != 16'd0)
    else $error("token beat with status or empty run");

  a_partner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == bftl_pkg::KIND_TOKEN &&
      out_token_type != bftl_pkg::TOK_CLOSE |-> out_partner_index == 16'd0)
    else $error("partner index on a non-close token");

  // input held off only with results waiting
  a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing to send");

endmodule

bind brainfuck_token_lexer bftl_checker u_bftl_checker (.*);
